// ----- design/cvsd_pkg.sv -----
// Shared types and constants of the CAN vehicle signal decoder.
// No dependencies; imported by every module of the block except cvsd_fifo.
package cvsd_pkg;

  localparam int ID_BITS_DEF = 11;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int MID_DEPTH   = 2;
  localparam int OUT_DEPTH   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b1;

  localparam logic [15:0] PERIOD_RST = 16'd399;

  localparam logic [10:0] ID_GEAR   = 11'h0D0;
  localparam logic [10:0] ID_LIGHT  = 11'h0C8;
  localparam logic [10:0] ID_TURN   = 11'h310;
  localparam logic [10:0] ID_ENGINE = 11'h340;
  localparam logic [10:0] ID_DOOR   = 11'h360;
  localparam logic [10:0] ID_STEER  = 11'h0B0;
  localparam logic [10:0] ID_SPEED  = 11'h130;
  localparam logic [10:0] ID_THROT  = 11'h080;
  localparam logic [10:0] ID_BRAKE  = 11'h252;
  localparam logic [10:0] ID_RPM    = 11'h090;

  localparam logic [7:0] ENG_ON_CODE  = 8'h66;
  localparam logic [7:0] ENG_OFF_CODE = 8'h6E;

  // reciprocal multipliers, exact over the full operand range
  localparam logic [16:0] RCP_SPEED   = 17'd83887;   // /100, >>23
  localparam logic [16:0] RCP_BRAKE   = 17'd104858;  // /20,  >>21
  localparam logic [16:0] RCP_THROT   = 17'd3277;    // /10,  >>15
  localparam logic [16:0] STEER_SCALE = 17'd450;     // *450, >>15
  localparam int SH_SPEED = 23;
  localparam int SH_BRAKE = 21;
  localparam int SH_FIX15 = 15;

  localparam logic signed [12:0] STEER_OFF = 13'sd450;
  localparam logic [8:0]         THROT_MAX = 9'd100;
  localparam logic [7:0]         THROT_BAD = 8'hFF;

  typedef enum logic [3:0] {
    K_NONE, K_GEAR, K_LIGHT, K_TURN, K_ENG_ON, K_ENG_OFF,
    K_DOOR, K_STEER, K_SPEED, K_THROT, K_BRAKE, K_RPM
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] arg;
    logic        emit;
  } cmd_t;

  typedef struct packed {
    logic        [15:0] trip_count;
    logic        [9:0]  speed_kmh;
    logic        [12:0] engine_rpm;
    logic signed [7:0]  throttle_percent;
    logic signed [11:0] steering_value;
    logic        [3:0]  gear_position;
    logic        [7:0]  light_status;
    logic        [3:0]  door_bits;
    logic        [1:0]  turn_signal;
    logic        [11:0] brake_level;
  } rec_t;

endpackage

// ----- design/can_vehicle_signal_decoder_top.sv -----
// Top level of the CAN vehicle signal decoder.
// Depends on cvsd_pkg, cvsd_front, cvsd_back and cvsd_fifo.
//
// Takes one CAN frame per clock through a queue-style push/full port and
// keeps the latest decoded vehicle signals. Every frame is classified by
// identifier in the front end, queued, then decoded by the back end through
// one shared 17x17 reciprocal multiplier stage and committed in order. With
// snapshots enabled, a frame that finds the frame counter at or above
// snapshot_period pushes the full signal record (as of that frame) into the
// result queue. A record passes the command queue, the multiplier stage and
// the result queue. Sustained rate is one frame per cycle; full rises only
// when the result queue is full and stalls the back end.
module can_vehicle_signal_decoder_top import cvsd_pkg::*; #(
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [ID_BITS-1:0]    in_frame_id,
  input  logic [7:0]            in_data_byte0,
  input  logic [7:0]            in_data_byte1,
  input  logic [7:0]            in_data_byte2,
  input  logic [7:0]            in_data_byte3,
  input  logic [7:0]            in_data_byte4,
  input  logic [7:0]            in_data_byte5,
  input  logic [7:0]            in_data_byte6,
  input  logic [7:0]            in_data_byte7,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [15:0]           out_trip_count,
  output logic [9:0]            out_speed_kmh,
  output logic [12:0]           out_engine_rpm,
  output logic signed [7:0]     out_throttle_percent,
  output logic signed [11:0]    out_steering_value,
  output logic [3:0]            out_gear_position,
  output logic [7:0]            out_light_status,
  output logic [3:0]            out_door_bits,
  output logic [1:0]            out_turn_signal,
  output logic [11:0]           out_brake_level,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic mid_push, mid_full, mid_pop, mid_empty;
  cmd_t mid_in, mid_out;
  logic res_push, res_full;
  rec_t res_in, res_out;
  logic unused_byte3;

  assign unused_byte3 = ^in_data_byte3;

  cvsd_front #(.ID_BITS(ID_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_frame_id   (in_frame_id),
    .in_data_byte0 (in_data_byte0),
    .in_data_byte1 (in_data_byte1),
    .in_data_byte2 (in_data_byte2),
    .in_data_byte4 (in_data_byte4),
    .in_data_byte5 (in_data_byte5),
    .in_data_byte6 (in_data_byte6),
    .in_data_byte7 (in_data_byte7 ^ {7'd0, unused_byte3 & 1'b0}),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mid_full      (mid_full),
    .mid_push      (mid_push),
    .mid_cmd       (mid_in)
  );

  cvsd_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .din   (mid_in),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_out),
    .empty (mid_empty)
  );

  cvsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_cmd   (mid_out),
    .mid_pop   (mid_pop),
    .out_full  (res_full),
    .out_push  (res_push),
    .out_rec   (res_in)
  );

  cvsd_fifo #(.WIDTH($bits(rec_t)), .DEPTH(OUT_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_out),
    .empty (out_empty)
  );

  assign in_full              = mid_full;
  assign out_trip_count       = res_out.trip_count;
  assign out_speed_kmh        = res_out.speed_kmh;
  assign out_engine_rpm       = res_out.engine_rpm;
  assign out_throttle_percent = res_out.throttle_percent;
  assign out_steering_value   = res_out.steering_value;
  assign out_gear_position    = res_out.gear_position;
  assign out_light_status     = res_out.light_status;
  assign out_door_bits        = res_out.door_bits;
  assign out_turn_signal      = res_out.turn_signal;
  assign out_brake_level      = res_out.brake_level;

endmodule

// ----- design/cvsd_fifo.sv -----
// Small register FIFO with queue-style push/full and pop/empty ports.
// No dependencies; used for the command queue and the result queue.
module cvsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- design/cvsd_front.sv -----
// Front end: frame transfer, identifier classification, snapshot timing, config.
// Depends on cvsd_pkg; feeds the command queue.
module cvsd_front import cvsd_pkg::*; #(
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic [ID_BITS-1:0]    in_frame_id,
  input  logic [7:0]            in_data_byte0,
  input  logic [7:0]            in_data_byte1,
  input  logic [7:0]            in_data_byte2,
  input  logic [7:0]            in_data_byte4,
  input  logic [7:0]            in_data_byte5,
  input  logic [7:0]            in_data_byte6,
  input  logic [7:0]            in_data_byte7,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  mid_full,
  output logic                  mid_push,
  output cmd_t                  mid_cmd
);

  logic [15:0] period_r;
  logic        enable_r;
  logic [15:0] cnt_r, cnt_nxt;
  logic        emit;
  kind_t       kind;

  always_comb begin
    case (in_frame_id)
      ID_BITS'(ID_GEAR):   kind = K_GEAR;
      ID_BITS'(ID_LIGHT):  kind = K_LIGHT;
      ID_BITS'(ID_TURN):   kind = K_TURN;
      ID_BITS'(ID_ENGINE): begin
        if (in_data_byte6 == ENG_ON_CODE) begin
          kind = K_ENG_ON;
        end else if (in_data_byte6 == ENG_OFF_CODE) begin
          kind = K_ENG_OFF;
        end else begin
          kind = K_NONE;
        end
      end
      ID_BITS'(ID_DOOR):   kind = K_DOOR;
      ID_BITS'(ID_STEER):  kind = K_STEER;
      ID_BITS'(ID_SPEED):  kind = K_SPEED;
      ID_BITS'(ID_THROT):  kind = K_THROT;
      ID_BITS'(ID_BRAKE):  kind = K_BRAKE;
      ID_BITS'(ID_RPM):    kind = K_RPM;
      default:             kind = K_NONE;
    endcase
  end

  always_comb begin
    mid_cmd.kind = kind;
    mid_cmd.emit = emit;
    case (kind)
      K_GEAR:  mid_cmd.arg = {12'd0, in_data_byte2[7:4]};
      K_LIGHT: mid_cmd.arg = {8'd0, in_data_byte7};
      K_TURN:  mid_cmd.arg = {14'd0, in_data_byte4[7:6]};
      K_DOOR:  mid_cmd.arg = {12'd0, in_data_byte2[3:0]};
      K_STEER: mid_cmd.arg = {in_data_byte5, in_data_byte6};
      K_SPEED: mid_cmd.arg = {in_data_byte6, in_data_byte7};
      K_THROT: mid_cmd.arg = {4'd0, in_data_byte0[3:0], in_data_byte1};
      K_BRAKE: mid_cmd.arg = {in_data_byte1, in_data_byte2};
      K_RPM:   mid_cmd.arg = {4'd0, in_data_byte4[3:0], in_data_byte5};
      default: mid_cmd.arg = '0;
    endcase
  end

  assign mid_push = in_push && !mid_full;
  assign emit     = enable_r && (cnt_r >= period_r);
  assign cnt_nxt  = (emit ? 16'd0 : cnt_r) + 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      enable_r <= 1'b1;
      cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PERIOD: period_r <= cfg_data[15:0];
          CFG_ENABLE: enable_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (mid_push && enable_r) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

endmodule

// ----- design/cvsd_back.sv -----
// Back end: shared reciprocal multiplier stage, then decode commit into the
// signal registers and record transfer. Depends on cvsd_pkg.
module cvsd_back import cvsd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic mid_empty,
  input  cmd_t mid_cmd,
  output logic mid_pop,
  input  logic out_full,
  output logic out_push,
  output rec_t out_rec
);

  logic        a_valid_r;
  kind_t       a_kind_r;
  logic [15:0] a_arg_r;
  logic        a_emit_r;
  logic        a_neg_r;
  logic [33:0] a_prod_r;

  logic        a_adv, commit;
  logic [15:0] w;
  logic [16:0] mul_a, mul_b;

  logic [3:0]  gear_r, gear_nxt;
  logic [7:0]  light_r, light_nxt;
  logic [1:0]  turn_r, turn_nxt;
  logic [3:0]  door_r, door_nxt;
  logic [11:0] steer_r, steer_nxt;
  logic [9:0]  speed_r, speed_nxt;
  logic [7:0]  throt_r, throt_nxt;
  logic [11:0] brake_r, brake_nxt;
  logic [12:0] rpm_r, rpm_nxt;
  logic        eng_on_r, eng_on_nxt;
  logic [15:0] trip_r, trip_nxt;

  logic [8:0]         quo15;
  logic signed [12:0] q_s, v_s, s3;

  assign commit  = a_valid_r && (!a_emit_r || !out_full);
  assign a_adv   = !a_valid_r || commit;
  assign mid_pop = a_adv && !mid_empty;
  assign w       = ~mid_cmd.arg;

  always_comb begin
    mul_b = '0;
    mul_a = {1'b0, mid_cmd.arg};
    case (mid_cmd.kind)
      K_STEER: begin
        mul_a = w[15] ? ({1'b0, mid_cmd.arg} + 17'd1) : {1'b0, w};
        mul_b = STEER_SCALE;
      end
      K_SPEED: mul_b = RCP_SPEED;
      K_THROT: mul_b = RCP_THROT;
      K_BRAKE: mul_b = RCP_BRAKE;
      default: mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_adv) begin
      a_valid_r <= !mid_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      a_kind_r <= mid_cmd.kind;
      a_arg_r  <= mid_cmd.arg;
      a_emit_r <= mid_cmd.emit;
      a_neg_r  <= w[15];
      a_prod_r <= mul_a * mul_b;
    end
  end

  assign quo15 = a_prod_r[SH_FIX15 +: 9];

  always_comb begin
    q_s = a_neg_r ? -$signed({4'd0, quo15}) : $signed({4'd0, quo15});
    v_s = (q_s > 13'sd0) ? (q_s - STEER_OFF) : (q_s + STEER_OFF);
    s3  = (v_s <<< 1) + v_s;
  end

  always_comb begin
    gear_nxt   = gear_r;
    light_nxt  = light_r;
    turn_nxt   = turn_r;
    door_nxt   = door_r;
    steer_nxt  = steer_r;
    speed_nxt  = speed_r;
    throt_nxt  = throt_r;
    brake_nxt  = brake_r;
    rpm_nxt    = rpm_r;
    eng_on_nxt = eng_on_r;
    trip_nxt   = trip_r;
    case (a_kind_r)
      K_GEAR:  gear_nxt  = a_arg_r[3:0];
      K_LIGHT: light_nxt = a_arg_r[7:0];
      K_TURN:  turn_nxt  = a_arg_r[1:0];
      K_DOOR:  door_nxt  = a_arg_r[3:0];
      K_STEER: steer_nxt = s3[11:0];
      K_SPEED: speed_nxt = a_prod_r[SH_SPEED +: 10];
      K_THROT: throt_nxt = (quo15 > THROT_MAX) ? THROT_BAD : quo15[7:0];
      K_BRAKE: brake_nxt = a_prod_r[SH_BRAKE +: 12];
      K_RPM:   rpm_nxt   = {a_arg_r[11:0], 1'b0};
      K_ENG_ON: begin
        if (!eng_on_r && (trip_r != 16'hFFFF)) begin
          trip_nxt = trip_r + 16'd1;
        end
        eng_on_nxt = 1'b1;
      end
      K_ENG_OFF: eng_on_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gear_r   <= '0;
      light_r  <= '0;
      turn_r   <= '0;
      door_r   <= '0;
      steer_r  <= '0;
      speed_r  <= '0;
      throt_r  <= '0;
      brake_r  <= '0;
      rpm_r    <= '0;
      eng_on_r <= 1'b0;
      trip_r   <= '0;
    end else if (commit) begin
      gear_r   <= gear_nxt;
      light_r  <= light_nxt;
      turn_r   <= turn_nxt;
      door_r   <= door_nxt;
      steer_r  <= steer_nxt;
      speed_r  <= speed_nxt;
      throt_r  <= throt_nxt;
      brake_r  <= brake_nxt;
      rpm_r    <= rpm_nxt;
      eng_on_r <= eng_on_nxt;
      trip_r   <= trip_nxt;
    end
  end

  assign out_push = commit && a_emit_r;

  always_comb begin
    out_rec.trip_count       = trip_nxt;
    out_rec.speed_kmh        = speed_nxt;
    out_rec.engine_rpm       = rpm_nxt;
    out_rec.throttle_percent = throt_nxt;
    out_rec.steering_value   = steer_nxt;
    out_rec.gear_position    = gear_nxt;
    out_rec.light_status     = light_nxt;
    out_rec.door_bits        = door_nxt;
    out_rec.turn_signal      = turn_nxt;
    out_rec.brake_level      = brake_nxt;
  end

endmodule
